[src/v4alu_pkg.sv]
// Package: action codes, status codes and sequencer states for the vector ALU.
`timescale 1ns / 1ps
package v4alu_pkg;

    typedef enum logic [3:0] {
        ACT_ADD       = 4'd0,
        ACT_SUB       = 4'd1,
        ACT_NEG       = 4'd2,
        ACT_MUL       = 4'd3,
        ACT_DIV       = 4'd4,
        ACT_DOT4      = 4'd5,
        ACT_DOT3      = 4'd6,
        ACT_LEN4      = 4'd7,
        ACT_LEN3      = 4'd8,
        ACT_NORM4     = 4'd9,
        ACT_NORM3     = 4'd10,
        ACT_CROSS     = 4'd11,
        ACT_LOADROW   = 4'd12,
        ACT_TRANSFORM = 4'd13,
        ACT_RSV14     = 4'd14,
        ACT_RSV15     = 4'd15
    } action_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_DIVZ = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SQRT,
        ST_DIVSETUP,
        ST_DIV,
        ST_DIVDONE,
        ST_DONE
    } state_t;

endpackage

[src/vector4_fixed_alu.sv]
// Top level: sequenced Q-format vector ALU with one shared multiplier, divider and root unit.
// Transform forms one product per cycle; len4 and len3 take 32 root steps; div, norm3 and norm4
// run each component through the bit-serial divider, and a zero length or zero divisor skips it.
// Throughput: one item at a time; busy is high from the accepting edge until the done strobe
// cycle. Reset: async active low clears sequencer, matrix.
`timescale 1ns / 1ps
module vector4_fixed_alu import v4alu_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [3:0]         action,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] b_w,
    input  logic signed [31:0] scalar,
    input  logic [1:0]         row_select,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic signed [31:0] r_w,
    output logic signed [31:0] r_scalar,
    output logic [1:0]         status
);
    localparam int SW = (COMP_WIDTH < 32) ? COMP_WIDTH : 32;
    localparam logic signed [31:0] HI32 = 32'(((64'sd1 <<< (SW - 1)) - 1));
    localparam logic signed [31:0] LO32 = -HI32 - 32'sd1;
    localparam logic signed [71:0] HI72 = 72'(HI32);
    localparam logic signed [71:0] LO72 = 72'(LO32);

    // clamp an input word into the component range
    function automatic logic signed [31:0] clamp_in(input logic signed [31:0] v);
        if (v > HI32) return HI32;
        if (v < LO32) return LO32;
        return v;
    endfunction

    state_t state_reg, state_next;
    action_t act_reg;
    logic signed [31:0] a_reg [4];
    logic signed [31:0] b_reg [4];
    logic signed [31:0] s_reg;
    logic [1:0]  row_reg;
    logic [31:0] mat_reg [16];

    logic [4:0]  step_reg;      // product / component index
    logic [1:0]  comp_reg;      // output component
    logic signed [71:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic        prod_v_reg;
    logic signed [31:0] v_reg [4];
    logic signed [31:0] sc_reg;
    logic        flag_reg, dz_reg;
    logic [63:0] sq_reg;        // sum of squares (clamped)
    logic [31:0] root_reg;
    logic [63:0] rem_reg;
    logic [5:0]  rcnt_reg;
    logic        done_reg;

    // root step signals
    logic [65:0] r_trial;
    logic [65:0] r_rem2;

    // multiplier operand select
    logic signed [31:0] op_a, op_b;
    logic               neg_p;
    logic [4:0]         nprod;
    logic               last_prod;

    // divider
    logic        d_go, d_done;
    logic [63:0] d_num, d_quot;
    logic [63:0] d_den;
    logic        d_neg;
    logic signed [31:0] d_src;
    logic signed [64:0] d_sq;
    logic        d_neg_reg;

    v4alu_div #(.NUM_W(64), .DEN_W(64)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (d_go),
        .num  (d_num),
        .den  (d_den),
        .done (d_done),
        .quot (d_quot)
    );

    // product count per action
    always_comb
    begin
        case (act_reg)
            ACT_MUL, ACT_DOT4, ACT_LEN4, ACT_NORM4: nprod = 5'd4;
            ACT_DOT3, ACT_LEN3, ACT_NORM3:          nprod = 5'd3;
            ACT_CROSS:                              nprod = 5'd6;
            ACT_TRANSFORM:                          nprod = 5'd16;
            default:                                nprod = 5'd0;
        endcase
    end

    // operand select for the shared multiplier
    always_comb
    begin
        op_a  = a_reg[step_reg[1:0]];
        op_b  = b_reg[step_reg[1:0]];
        neg_p = 1'b0;
        case (act_reg)
            ACT_MUL: op_b = s_reg;
            ACT_LEN4, ACT_LEN3, ACT_NORM4, ACT_NORM3: op_b = a_reg[step_reg[1:0]];
            ACT_TRANSFORM:
            begin
                op_a = a_reg[step_reg[1:0]];
                op_b = mat_reg[step_reg[3:0]];
            end
            ACT_CROSS:
            begin
                neg_p = step_reg[0];
                case (step_reg[2:0])
                    3'd0: begin op_a = a_reg[1]; op_b = b_reg[2]; end
                    3'd1: begin op_a = a_reg[2]; op_b = b_reg[1]; end
                    3'd2: begin op_a = a_reg[2]; op_b = b_reg[0]; end
                    3'd3: begin op_a = a_reg[0]; op_b = b_reg[2]; end
                    3'd4: begin op_a = a_reg[0]; op_b = b_reg[1]; end
                    default: begin op_a = a_reg[1]; op_b = b_reg[0]; end
                endcase
            end
            default: ;
        endcase
    end

    assign last_prod = (step_reg == nprod - 5'd1);

    // root: classic digit-by-digit, two radicand bits per step
    assign r_rem2  = {rem_reg, sq_reg[63:62]};
    assign r_trial = {32'd0, root_reg, 2'b01};

    // divider operands: component times 2^FRAC over unsigned length or |scalar|
    assign d_src = a_reg[comp_reg];
    assign d_sq  = 65'(d_src) <<< FRAC_BITS;
    always_comb
    begin
        d_num = d_sq[64] ? 64'(-d_sq) : d_sq[63:0];
        if (act_reg == ACT_DIV)
        begin
            d_den = s_reg[31] ? 64'(-65'(s_reg)) : 64'(s_reg);
            d_neg = d_sq[64] ^ s_reg[31];
        end
        else
        begin
            d_den = {32'd0, root_reg};
            d_neg = d_sq[64];
        end
    end
    // a zero length skips the divide altogether
    assign d_go = (state_reg == ST_DIVSETUP) && !(act_reg != ACT_DIV && root_reg == 32'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_MUL;
            ST_MUL:
                case (act_reg)
                    ACT_ADD, ACT_SUB, ACT_NEG, ACT_LOADROW,
                    ACT_RSV14, ACT_RSV15: state_next = ST_DONE;
                    ACT_DIV: state_next = (s_reg == 0) ? ST_DONE : ST_DIVSETUP;
                    default: if (last_prod) state_next = ST_ACC;
                endcase
            ST_ACC:
                case (act_reg)
                    ACT_LEN4, ACT_LEN3, ACT_NORM4, ACT_NORM3: state_next = ST_SQRT;
                    default: state_next = ST_DONE;
                endcase
            ST_SQRT:
                if (rcnt_reg == 6'd31)
                begin
                    if (act_reg == ACT_NORM4 || act_reg == ACT_NORM3)
                        state_next = ST_DIVSETUP;
                    else
                        state_next = ST_DONE;
                end
            ST_DIVSETUP:
                state_next = (act_reg != ACT_DIV && root_reg == 32'd0) ? ST_DONE : ST_DIV;
            ST_DIV:
                if (d_done)
                    state_next = ST_DIVDONE;
            ST_DIVDONE:
                if ((act_reg == ACT_NORM3 && comp_reg == 2'd2) || comp_reg == 2'd3)
                    state_next = ST_DONE;
                else
                    state_next = ST_DIVSETUP;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
            if (state_reg == ST_MUL && act_reg == ACT_LOADROW)
                for (int j = 0; j < 4; j++)
                    mat_reg[{row_reg, 2'(j)}] <= a_reg[j];
        end
    end

    // datapath
    logic signed [71:0] acc_in;
    logic signed [71:0] fl;
    logic signed [71:0] qv;
    logic signed [71:0] sat_in;
    logic signed [31:0] sat_out;
    logic               sat_hit;

    assign acc_in = acc_reg + (prod_v_reg ? 72'(prod_reg) : 72'sd0);
    assign fl     = acc_in >>> FRAC_BITS;
    assign qv     = d_neg_reg ? -72'(d_quot) : 72'(d_quot);

    always_comb
    begin
        sat_in = fl;
        if (state_reg == ST_DIV)
            sat_in = qv;
        sat_hit = (sat_in > HI72) || (sat_in < LO72);
        sat_out = (sat_in > HI72) ? HI32 : ((sat_in < LO72) ? LO32 : 32'(sat_in));
    end

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v, output logic f);
        f = 1'b0;
        if (v > 33'(HI32)) begin f = 1'b1; return HI32; end
        if (v < 33'(LO32)) begin f = 1'b1; return LO32; end
        return 32'(v);
    endfunction

    logic [63:0] sq_sum;
    logic [64:0] sq_wide;
    assign sq_wide = {1'b0, sq_reg} + {1'b0, prod_reg[63:0]};
    assign sq_sum  = sq_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_wide[63:0];

    always_ff @(posedge clk)
    begin
        logic f;
        logic fa;
        logic signed [32:0] addv;
        logic signed [31:0] t;
        f = 1'b0;
        fa = 1'b0;
        addv = '0;
        t = '0;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    act_reg  <= action_t'(action);
                    a_reg[0] <= clamp_in(a_x); a_reg[1] <= clamp_in(a_y);
                    a_reg[2] <= clamp_in(a_z); a_reg[3] <= clamp_in(a_w);
                    b_reg[0] <= clamp_in(b_x); b_reg[1] <= clamp_in(b_y);
                    b_reg[2] <= clamp_in(b_z); b_reg[3] <= clamp_in(b_w);
                    s_reg    <= clamp_in(scalar);
                    row_reg  <= row_select;
                    step_reg <= '0;
                    comp_reg <= '0;
                    acc_reg  <= '0;
                    sq_reg   <= '0;
                    prod_v_reg <= 1'b0;
                    for (int i = 0; i < 4; i++) v_reg[i] <= '0;
                    sc_reg   <= '0;
                    flag_reg <= 1'b0;
                    dz_reg   <= 1'b0;
                end
            ST_MUL:
            begin
                case (act_reg)
                    ACT_ADD, ACT_SUB, ACT_NEG:
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            if (act_reg == ACT_ADD) addv = 33'(a_reg[i]) + 33'(b_reg[i]);
                            else if (act_reg == ACT_SUB) addv = 33'(a_reg[i]) - 33'(b_reg[i]);
                            else addv = -33'(a_reg[i]);
                            v_reg[i] <= sat33(addv, f);
                            fa = fa | f;
                        end
                        if (fa) flag_reg <= 1'b1;
                    end
                    ACT_DIV:
                        if (s_reg == 0) dz_reg <= 1'b1;
                    default:
                    begin
                        prod_reg   <= neg_p ? -(64'(op_a) * 64'(op_b)) : 64'(op_a) * 64'(op_b);
                        prod_v_reg <= (nprod != 5'd0);
                        step_reg   <= step_reg + 5'd1;
                    end
                endcase
                // fold previous product
                if (prod_v_reg)
                begin
                    case (act_reg)
                        ACT_LEN4, ACT_LEN3, ACT_NORM4, ACT_NORM3: sq_reg <= sq_sum;
                        ACT_MUL:
                        begin
                            v_reg[comp_reg] <= sat_out;
                            if (sat_hit) flag_reg <= 1'b1;
                            comp_reg <= comp_reg + 2'd1;
                        end
                        ACT_CROSS:
                            if (step_reg[0])
                                acc_reg <= 72'(prod_reg);
                            else
                            begin
                                v_reg[comp_reg] <= sat_out;
                                if (sat_hit) flag_reg <= 1'b1;
                                comp_reg <= comp_reg + 2'd1;
                                acc_reg  <= '0;
                            end
                        ACT_TRANSFORM:
                            if (step_reg[1:0] != 2'd0)
                                acc_reg <= acc_in;
                            else
                            begin
                                v_reg[comp_reg] <= sat_out;
                                if (sat_hit) flag_reg <= 1'b1;
                                comp_reg <= comp_reg + 2'd1;
                                acc_reg  <= '0;
                            end
                        default: acc_reg <= acc_in;
                    endcase
                end
            end
            ST_ACC:
            begin
                rem_reg  <= '0;
                root_reg <= '0;
                rcnt_reg <= '0;
                case (act_reg)
                    ACT_LEN4, ACT_LEN3, ACT_NORM4, ACT_NORM3: sq_reg <= sq_sum;
                    ACT_DOT4, ACT_DOT3:
                    begin
                        sc_reg <= sat_out;
                        if (sat_hit) flag_reg <= 1'b1;
                    end
                    default:
                    begin
                        v_reg[comp_reg] <= sat_out;
                        if (sat_hit) flag_reg <= 1'b1;
                    end
                endcase
                comp_reg <= '0;
            end
            ST_SQRT:
            begin
                rcnt_reg <= rcnt_reg + 6'd1;
                sq_reg   <= {sq_reg[61:0], 2'b00};
                if (r_rem2 >= r_trial)
                begin
                    rem_reg  <= 64'(r_rem2 - r_trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= r_rem2[63:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                if (rcnt_reg == 6'd31 && (act_reg == ACT_LEN4 || act_reg == ACT_LEN3))
                begin
                    t = (r_rem2 >= r_trial) ? {root_reg[30:0], 1'b1} : {root_reg[30:0], 1'b0};
                    if ({1'b0, t} > 33'(HI32))
                    begin
                        sc_reg   <= HI32;
                        flag_reg <= 1'b1;
                    end
                    else
                        sc_reg <= t;
                end
            end
            ST_DIVSETUP:
                d_neg_reg <= d_neg;
            ST_DIV:
                if (d_done)
                begin
                    v_reg[comp_reg] <= sat_out;
                    if (sat_hit) flag_reg <= 1'b1;
                end
            ST_DIVDONE:
                comp_reg <= comp_reg + 2'd1;
            ST_DONE: ;
            default: ;
        endcase
    end

    // outputs
    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            r_x      <= v_reg[0];
            r_y      <= v_reg[1];
            r_z      <= v_reg[2];
            r_w      <= v_reg[3];
            r_scalar <= sc_reg;
            status   <= dz_reg ? STAT_DIVZ : (flag_reg ? STAT_SAT : STAT_OK);
        end
    end

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_div_go: assert property (@(posedge clk) disable iff (!rst_n)
        d_done |-> state_reg == ST_DIV) else $error("divider done out of place");
`endif
endmodule

[src/v4alu_div.sv]
// Shared restoring divider: unsigned numerator over unsigned divisor, one bit per cycle.
`timescale 1ns / 1ps
module v4alu_div import v4alu_pkg::*; #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [NUM_W-1:0]   quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};

    // one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quot = (trial >= {1'b0, den_reg}) ? {q_reg[NUM_W-2:0], 1'b1}
                                             : {q_reg[NUM_W-2:0], 1'b0};

`ifndef SYNTHESIS
    a_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0) else $error("divider count zero while busy");
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy_reg) else $error("divider not started");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg) else $error("divider busy after done");
`endif
endmodule
